### hdl/amna_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amna_pkg: shared types and constants of the A-scan median/normalize block
// Payload structs, register indexes and default register values.
// ---------------------------------------------------------------------------
package amna_pkg;

  localparam int unsigned LineMaxDef    = 1024;
  localparam int unsigned WindowSizeDef = 5;
  localparam int unsigned IdxW          = 10;

  localparam logic [2:0] RegLow    = 3'd0;
  localparam logic [2:0] RegHigh   = 3'd1;
  localparam logic [2:0] RegGain   = 3'd2;
  localparam logic [2:0] RegStep   = 3'd3;
  localparam logic [2:0] RegTarget = 3'd4;

  localparam logic [15:0] LowRst    = 16'd320;
  localparam logic [15:0] HighRst   = 16'd560;
  localparam logic [23:0] GainRst   = 24'd69904;
  localparam logic [15:0] StepRst   = 16'd4;
  localparam logic [15:0] TargetRst = 16'd30;

  typedef struct packed {
    logic [15:0]        sample;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               end_of_line;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0]    point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        intensity;
    logic               averaged;
    logic               last_point;
    logic               target_reached;
  } out_req_t;

endpackage

### hdl/amna_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amna_cell: one tap of the sample window
// Holds one sample and passes it to the next cell on every shift.
// ---------------------------------------------------------------------------
module amna_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  logic [15:0] data_i,
  output logic [15:0] data_o
);
  logic [15:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;
endmodule

### hdl/amna_median.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amna_median: median of a small window
// Rank count over the taps; the element with the middle rank is chosen.
// ---------------------------------------------------------------------------
module amna_median #(
  parameter int unsigned WindowSize = 5
) (
  input  logic [WindowSize*16-1:0] win_i,
  output logic [15:0]              med_o
);
  localparam int unsigned Mid = WindowSize / 2;
  localparam int unsigned CntW = $clog2(WindowSize + 1);

  always_comb begin
    logic [CntW-1:0] less, leq;
    med_o = '0;
    for (int i = 0; i < WindowSize; i++) begin
      less = '0;
      leq  = '0;
      for (int j = 0; j < WindowSize; j++) begin
        if (win_i[j*16 +: 16] < win_i[i*16 +: 16]) less = less + 1'b1;
        if (win_i[j*16 +: 16] <= win_i[i*16 +: 16]) leq = leq + 1'b1;
      end
      if (less <= CntW'(Mid) && leq > CntW'(Mid)) med_o = win_i[i*16 +: 16];
    end
  end
endmodule

### hdl/ascan_median_normalize_average.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ascan_median_normalize_average: A-scan median, normalization, averaging
// Median over a row of window cells, clamp and Q16.8 gain scaling, line store
// averaging at repeated stage positions.
// ---------------------------------------------------------------------------
//  channel | dir | payload          | handshake
//  in      | in  | in_req_t         | in_valid_i / in_stall_o
//  out     | out | out_req_t        | out_valid_o / out_stall_i
//  cfg     | in  | 32-bit registers | APB, pready always high
//
// One sample per cycle, back to back, while in_stall_o is low. A sample with a
// full window issues its median point in the cycle it is accepted; the point
// passes clamp and gain multiply, round and store read, average and write back,
// then a four-deep output queue before it shows on out_valid_o.
// A sample that ends a line adds a zero tail of up to 2*(WindowSize/2) points,
// issued one per cycle with room, as in_stall_o holds the input. It also rises
// when pipeline plus queue hold four points and none leaves in this cycle.
// Control and registers reset asynchronously; no clearing pass after reset.
// ---------------------------------------------------------------------------
module ascan_median_normalize_average
  import amna_pkg::*;
#(
  parameter int unsigned LineMax    = LineMaxDef,
  parameter int unsigned WindowSize = WindowSizeDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  amna_pkg::in_req_t     in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output amna_pkg::out_req_t    out_req_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int unsigned Hist = 2 * (WindowSize / 2);
  localparam int unsigned CntW = $clog2(LineMax + 1);
  localparam int unsigned AddrW = $clog2(LineMax);
  localparam int unsigned TailW = $clog2(Hist + 1);

  // configuration
  logic [15:0] low_q, high_q, step_q, target_q;
  logic [23:0] gain_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= LowRst; high_q <= HighRst; gain_q <= GainRst;
      step_q <= StepRst; target_q <= TargetRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegLow:    low_q <= pwdata[15:0];
        RegHigh:   high_q <= pwdata[15:0];
        RegGain:   gain_q <= pwdata[23:0];
        RegStep:   step_q <= pwdata[15:0];
        RegTarget: target_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegLow:    prdata = {16'd0, low_q};
      RegHigh:   prdata = {16'd0, high_q};
      RegGain:   prdata = {8'd0, gain_q};
      RegStep:   prdata = {16'd0, step_q};
      RegTarget: prdata = {16'd0, target_q};
      default:   prdata = '0;
    endcase
  end

  // input and line state
  logic           in_acc;
  logic [CntW-1:0] cnt_q;
  logic [31:0]    px_q, py_q, pz_q;
  logic           pvalid_q, avg_q;
  logic [15:0]    pose_q;
  logic [TailW-1:0] tail_q;     // zero-tail points still to emit
  logic [AddrW-1:0] tail_k_q;
  logic           busy;         // tail in progress
  logic           in_room;

  assign in_acc = in_valid_i && !in_stall_o;

  // window cells
  logic [15:0] tap [Hist+1];
  logic        shift;
  assign tap[0] = in_req_i.sample;
  assign shift = in_acc && (cnt_q < CntW'(LineMax));
  for (genvar g = 0; g < Hist; g++) begin : g_cell
    amna_cell u_cell (
      .clk_i, .rst_ni, .shift_i(shift), .data_i(tap[g]), .data_o(tap[g+1])
    );
  end

  logic [WindowSize*16-1:0] win;
  always_comb begin
    for (int i = 0; i <= Hist; i++) win[i*16 +: 16] = tap[i];
    for (int i = Hist + 1; i < WindowSize; i++) win[i*16 +: 16] = '0;
  end
  logic [15:0] med;
  amna_median #(.WindowSize(WindowSize)) u_med (.win_i(win), .med_o(med));

  // line start decision
  logic new_line, same_pos, avg_now;
  logic [31:0] cx, cy, cz;
  logic [15:0] pose_now;
  assign new_line = shift && (cnt_q == '0);
  assign same_pos = pvalid_q && in_req_i.pos_x == px_q && in_req_i.pos_y == py_q
                    && in_req_i.pos_z == pz_q;
  assign avg_now  = new_line ? same_pos : avg_q;
  assign cx = (new_line && !same_pos) ? in_req_i.pos_x : px_q;
  assign cy = (new_line && !same_pos) ? in_req_i.pos_y : py_q;
  assign cz = (new_line && !same_pos) ? in_req_i.pos_z : pz_q;
  assign pose_now = (new_line && !same_pos && pose_q != 16'hFFFF) ? pose_q + 16'd1
                    : pose_q;

  logic [CntW-1:0] cnt_after;
  assign cnt_after = shift ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; px_q <= '0; py_q <= '0; pz_q <= '0;
      pvalid_q <= 1'b0; avg_q <= 1'b0; pose_q <= '0;
      tail_q <= '0; tail_k_q <= '0;
    end else begin
      if (in_acc) begin
        px_q <= cx; py_q <= cy; pz_q <= cz; avg_q <= avg_now; pose_q <= pose_now;
        if (new_line) pvalid_q <= 1'b1;
        if (in_req_i.end_of_line) begin
          cnt_q <= '0;
          tail_q <= (cnt_after > CntW'(Hist)) ? TailW'(Hist) : TailW'(cnt_after);
          tail_k_q <= (cnt_after > CntW'(Hist)) ? AddrW'(cnt_after - CntW'(Hist)) : '0;
        end else begin
          cnt_q <= cnt_after;
        end
      end else if (tail_q != '0 && in_room) begin
        tail_q <= tail_q - 1'b1;
        tail_k_q <= tail_k_q + 1'b1;
      end
    end
  end

  // stage 0 issue: median point from input, else one tail point
  logic           iss_v;
  logic [AddrW-1:0] iss_k;
  logic [15:0]    iss_f;
  logic           iss_last;
  logic           med_v;
  assign med_v = shift && (cnt_q >= CntW'(Hist));
  always_comb begin
    iss_v = 1'b0; iss_k = '0; iss_f = '0; iss_last = 1'b0;
    if (med_v) begin
      iss_v = 1'b1; iss_k = AddrW'(cnt_q - CntW'(Hist)); iss_f = med;
    end else if (!in_acc && tail_q != '0 && in_room) begin
      iss_v = 1'b1; iss_k = tail_k_q; iss_last = (tail_q == TailW'(1));
    end
  end

  // pipeline: s1 clamp+mult, s2 round/sat + store read, s3 average + write
  typedef struct packed {
    logic [AddrW-1:0] k;
    logic [31:0] x, y, z;
    logic avg, last, tgt;
  } meta_t;
  meta_t iss_m, m1_q, m2_q, m3_q;
  assign iss_m = '{k: iss_k, x: cx, y: cy, z: cz, avg: avg_now, last: iss_last,
                   tgt: (pose_now >= target_q)};

  logic v1_q, v2_q, v3_q;
  logic [1:0] sel1_q;           // 0 zero, 1 full, 2 product
  logic [39:0] prod1_q;
  logic [15:0] n2_q, n3_q, rd2_q;
  logic [15:0] store [LineMax];
  logic [40:0] rnd;
  logic [AddrW+15:0] zoff1;
  assign rnd = {1'b0, prod1_q} + 41'd128;
  assign zoff1 = m1_q.k * step_q;

  always_ff @(posedge clk_i) begin
    if (iss_v) begin
      m1_q <= iss_m;
      prod1_q <= 40'(iss_f - low_q) * 40'(gain_q);
      sel1_q <= (iss_f < low_q) ? 2'd0 : (iss_f > high_q) ? 2'd1 : 2'd2;
    end
    m2_q <= '{k: m1_q.k, x: m1_q.x, y: m1_q.y, z: m1_q.z + 32'(zoff1),
              avg: m1_q.avg, last: m1_q.last, tgt: m1_q.tgt};
    case (sel1_q)
      2'd0: n2_q <= '0;
      2'd1: n2_q <= 16'hFFFF;
      default: n2_q <= (rnd[40:8] > 33'd65535) ? 16'hFFFF : rnd[23:8];
    endcase
    // take the value being written this cycle to the same entry
    rd2_q <= (v3_q && m3_q.k == m1_q.k) ? n3_q : store[m1_q.k];
    m3_q <= m2_q;
    // forward a write from the stage ahead to the same entry
    n3_q <= m2_q.avg ? 16'((17'(n2_q) + 17'((v3_q && m3_q.k == m2_q.k) ? n3_q : rd2_q))
                          >> 1) : n2_q;
    if (v3_q) store[m3_q.k] <= n3_q;
  end

  // output queue, four deep: room for every point the pipeline holds
  out_req_t   outq_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] qcnt_q;
  logic       pop, push;
  assign pop  = out_valid_o && !out_stall_i;
  assign push = v3_q;
  assign out_valid_o = qcnt_q != '0;
  assign out_req_o   = outq_q[rd_ptr_q];

  // points in flight plus queue must stay within four after a new issue
  logic [2:0] inflight;
  assign inflight = 3'(v1_q) + 3'(v2_q) + 3'(v3_q) + qcnt_q - 3'(pop);
  assign in_room  = inflight < 3'd4;
  assign busy     = tail_q != '0;
  assign in_stall_o = busy || !in_room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; qcnt_q <= '0;
      wr_ptr_q <= '0; rd_ptr_q <= '0;
    end else begin
      v1_q <= iss_v; v2_q <= v1_q; v3_q <= v2_q;
      qcnt_q <= qcnt_q + 3'(push) - 3'(pop);
      if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) outq_q[wr_ptr_q] <= '{IdxW'(m3_q.k), m3_q.x, m3_q.y, m3_q.z, n3_q,
        m3_q.avg, m3_q.last, m3_q.tgt};
  end

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) qcnt_q <= 3'd4)
    else $error("output queue overflow");
  a_no_in_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q != '0) |-> !in_acc) else $error("sample taken during tail");
  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |=> v2_q) else $error("pipeline lost a point");
endmodule
